/* rtl/iq12_packet_deframer_top_defines.svh */
// Assertion macros for the iq12 packet deframer.
// Used by iq12_packet_deframer_top.sv; expects clk and rst_n in scope.
`ifndef IQ12_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define IQ12_PACKET_DEFRAMER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define IQ12DFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iq12dfr: same-cycle check failed");
`define IQ12DFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iq12dfr: next-cycle check failed");
`else
`define IQ12DFR_ASSERT_IMP(label, ante, cons)
`define IQ12DFR_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/iq12dfr_pkg.sv */
// Shared constants and queue entry type for the iq12 packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package iq12dfr_pkg;

  localparam int unsigned NC_W             = 4;
  localparam int unsigned POS_W            = 14;
  localparam int unsigned CNT_W            = 12;
  localparam int unsigned HEADER_BYTES     = 16;
  localparam int unsigned MAX_PACKET_BYTES = 9000;
  localparam int unsigned MAX_CHANNELS     = 8;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 12'hfff;

  // One classified request from the byte parser to the result stage.
  typedef struct packed {
    logic               is_sample;
    logic               is_last;
    logic signed [15:0] i_value;
    logic signed [15:0] q_value;
    logic [2:0]         channel;
    logic [CNT_W-1:0]   spc_sample;  // per-channel index before this sample
    logic [63:0]        ptime;
    logic [CNT_W-1:0]   spc_end;     // per-channel count at packet end
    logic [15:0]        burst_field;
    logic [CNT_W-1:0]   total;
    logic               size_err;
    logic               hdr_full;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/iq12dfr_ifs.sv */
// Valid/ready channel interfaces: input byte stream and result stream.
// No dependencies.
`default_nettype none
interface iq12dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface iq12dfr_out_if;
  logic               valid;
  logic               ready;
  logic               sample_valid;
  logic signed [15:0] i_value;
  logic signed [15:0] q_value;
  logic [2:0]         channel;
  logic [63:0]        sample_time;
  logic               packet_end;
  logic [16:0]        burst_len;
  logic               short_burst;
  logic               discontinuous;
  logic               size_error;
  modport source (output valid, sample_valid, i_value, q_value, channel, sample_time,
                  packet_end, burst_len, short_burst, discontinuous, size_error,
                  input ready);
  modport sink (input valid, sample_valid, i_value, q_value, channel, sample_time,
                packet_end, burst_len, short_burst, discontinuous, size_error,
                output ready);
endinterface
`default_nettype wire

/* rtl/iq12dfr_front.sv */
// Byte parser: header fields, 3-byte sample groups, channel round robin.
// Depends on iq12dfr_pkg and iq12dfr_in_if; pushes requests into the queue.
`default_nettype none
module iq12dfr_front #(
  parameter int unsigned MAX_PACKET_BYTES = iq12dfr_pkg::MAX_PACKET_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [iq12dfr_pkg::NC_W-1:0] nc,
  iq12dfr_in_if.sink                   in_ch,
  input  logic                         q_full,
  output logic                         push,
  output iq12dfr_pkg::entry_t          push_entry
);
  import iq12dfr_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      burst_r, burst_nxt;
  logic [63:0]      ptime_r, ptime_nxt;
  logic [15:0]      held_r, held_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [2:0]       chan_r, chan_nxt;
  logic [CNT_W-1:0] spc_r, spc_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             accept;
  logic             dropped;
  logic             last;
  logic [7:0]       b;
  entry_t           ent;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.last_byte;
  assign dropped     = pos_r >= POS_W'(MAX_PACKET_BYTES);

  always_comb begin
    pos_nxt   = pos_r;
    burst_nxt = burst_r;
    ptime_nxt = ptime_r;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    chan_nxt  = chan_r;
    spc_nxt   = spc_r;
    total_nxt = total_r;
    ent       = '0;

    if (!dropped) begin
      if (pos_r < POS_W'(HEADER_BYTES)) begin
        // bytes 0,1: burst field; 8..15: timestamp; 2..7 ignored
        if (pos_r < POS_W'(2)) begin
          burst_nxt[{pos_r[0], 3'b000} +: 8] = b;
        end else if (pos_r[3]) begin
          ptime_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
        end
      end else begin
        case (phase_r)
          PH_FIRST: begin
            held_nxt  = {8'h00, b};
            phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            held_nxt[15:8] = b;
            phase_nxt      = PH_THIRD;
          end
          default: begin
            ent.is_sample  = 1'b1;
            ent.i_value    = {held_r[11:8], held_r[7:0], 4'h0};
            ent.q_value    = {b, held_r[15:12], 4'h0};
            ent.channel    = chan_r;
            ent.spc_sample = spc_r;
            phase_nxt      = PH_FIRST;
            held_nxt       = '0;
            if (total_r != COUNT_MAX) total_nxt = total_r + 1'b1;
            if (({1'b0, chan_r} + 4'd1) >= nc) begin
              chan_nxt = '0;
              if (spc_r != COUNT_MAX) spc_nxt = spc_r + 1'b1;
            end else begin
              chan_nxt = chan_r + 3'd1;
            end
          end
        endcase
      end
      pos_nxt = pos_r + 1'b1;
    end

    ent.ptime = ptime_nxt;

    if (last) begin
      ent.is_last     = 1'b1;
      ent.burst_field = burst_nxt;
      ent.total       = total_nxt;
      ent.spc_end     = spc_nxt;
      ent.size_err    = dropped || (pos_nxt <= POS_W'(HEADER_BYTES)) ||
                        (phase_nxt != PH_FIRST) || (chan_nxt != 3'd0);
      ent.hdr_full    = pos_nxt >= POS_W'(HEADER_BYTES);
      pos_nxt   = '0;
      burst_nxt = '0;
      ptime_nxt = '0;
      held_nxt  = '0;
      phase_nxt = PH_FIRST;
      chan_nxt  = '0;
      spc_nxt   = '0;
      total_nxt = '0;
    end
  end

  assign push       = accept && (ent.is_sample || last);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      burst_r <= '0;
      ptime_r <= '0;
      held_r  <= '0;
      phase_r <= PH_FIRST;
      chan_r  <= '0;
      spc_r   <= '0;
      total_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      burst_r <= burst_nxt;
      ptime_r <= ptime_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      chan_r  <= chan_nxt;
      spc_r   <= spc_nxt;
      total_r <= total_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/iq12dfr_queue.sv */
// Small circular queue of parsed requests between parser and result stage.
// Depends on iq12dfr_pkg (entry_t). DEPTH must be 2 or more.
`default_nettype none
module iq12dfr_queue #(
  parameter int unsigned DEPTH = iq12dfr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iq12dfr_pkg::entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output iq12dfr_pkg::entry_t head
);
  import iq12dfr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/iq12dfr_back.sv */
// Result stage: sample time, packet-end flags, expected-time tracking.
// Depends on iq12dfr_pkg and iq12dfr_out_if; drains the request queue.
`default_nettype none
module iq12dfr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [iq12dfr_pkg::NC_W-1:0] nc,
  input  iq12dfr_pkg::entry_t          head,
  input  logic                         not_empty,
  output logic                         pop,
  iq12dfr_out_if.source                out_ch
);
  import iq12dfr_pkg::*;

  logic               out_valid_r;
  logic               sample_valid_r;
  logic signed [15:0] i_value_r;
  logic signed [15:0] q_value_r;
  logic [2:0]         channel_r;
  logic [63:0]        sample_time_r;
  logic               packet_end_r;
  logic [16:0]        burst_len_r;
  logic               short_burst_r;
  logic               discontinuous_r;
  logic               size_error_r;
  logic [63:0]        expected_r;
  logic               time_known_r;

  logic [16:0] bc;
  logic [20:0] expect_samples;
  logic        upd_time;

  assign pop            = not_empty && (!out_valid_r || out_ch.ready);
  assign bc             = {1'b0, head.burst_field} + 17'd1;
  assign expect_samples = 21'(bc) * 21'(nc);
  assign upd_time       = head.is_last && head.hdr_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      expected_r   <= '0;
      time_known_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && upd_time) begin
        expected_r   <= head.ptime + 64'(head.spc_end);
        time_known_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sample_valid_r  <= head.is_sample;
      i_value_r       <= head.i_value;
      q_value_r       <= head.q_value;
      channel_r       <= head.channel;
      sample_time_r   <= head.is_sample ? head.ptime + 64'(head.spc_sample) : 64'd0;
      packet_end_r    <= head.is_last;
      burst_len_r     <= head.is_last ? bc : 17'd0;
      short_burst_r   <= head.is_last && (21'(head.total) != expect_samples);
      discontinuous_r <= upd_time && time_known_r && (expected_r != head.ptime);
      size_error_r    <= head.size_err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_valid  = sample_valid_r;
  assign out_ch.i_value       = i_value_r;
  assign out_ch.q_value       = q_value_r;
  assign out_ch.channel       = channel_r;
  assign out_ch.sample_time   = sample_time_r;
  assign out_ch.packet_end    = packet_end_r;
  assign out_ch.burst_len     = burst_len_r;
  assign out_ch.short_burst   = short_burst_r;
  assign out_ch.discontinuous = discontinuous_r;
  assign out_ch.size_error    = size_error_r;

endmodule
`default_nettype wire

/* rtl/iq12_packet_deframer_top.sv */
// Channel  | Dir | Handshake   | Payload
// in_ch    | in  | valid/ready | data_byte[7:0], last_byte
// out_ch   | out | valid/ready | sample, channel, time, packet-end flags
// cfg      | in  | cfg_wr_en   | cfg_wr_data[3:0] = channel count
//
// One byte per clock sustained while in_ch.ready is high. A byte that
// completes a sample or ends a packet is written into the 4-entry queue
// and then loaded into the output register when the queue head is popped.
// in_ch.ready drops only when the queue is full.
// Synchronous active-low reset, no clearing pass.
`default_nettype none
`include "iq12_packet_deframer_top_defines.svh"
module iq12_packet_deframer_top #(
  parameter int unsigned MAX_PACKET_BYTES = iq12dfr_pkg::MAX_PACKET_BYTES,
  parameter int unsigned QUEUE_DEPTH      = iq12dfr_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [iq12dfr_pkg::NC_W-1:0] cfg_wr_data,
  iq12dfr_in_if.sink                   in_ch,
  iq12dfr_out_if.source                out_ch
);
  import iq12dfr_pkg::*;

  logic [NC_W-1:0] chan_cfg_r;
  logic [NC_W-1:0] nc_eff;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  entry_t          q_in;
  entry_t          q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg_r <= NC_W'(1);
    end else if (cfg_wr_en) begin
      chan_cfg_r <= cfg_wr_data;
    end
  end

  // zero acts as one channel, above eight as eight
  always_comb begin
    if (chan_cfg_r == '0) begin
      nc_eff = NC_W'(1);
    end else if (chan_cfg_r > NC_W'(MAX_CHANNELS)) begin
      nc_eff = NC_W'(MAX_CHANNELS);
    end else begin
      nc_eff = chan_cfg_r;
    end
  end

  iq12dfr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .nc         (nc_eff),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  iq12dfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  iq12dfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nc        (nc_eff),
    .head      (q_head),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

  `IQ12DFR_ASSERT_IMP(a_result_kind, out_ch.valid && !out_ch.packet_end, out_ch.sample_valid)
  `IQ12DFR_ASSERT_IMP(a_burst_nonzero, out_ch.valid && out_ch.packet_end, out_ch.burst_len != '0)
  `IQ12DFR_ASSERT_IMP(a_full_stalls, q_full, !in_ch.ready)
  `IQ12DFR_ASSERT_NXT(a_pop_loads, q_pop, out_ch.valid)

endmodule
`default_nettype wire
